// File: rtl/core/lpbp_pkg.sv
// ----------------------------------------------------------------------------
// lpbp_pkg
// Types and constants shared by the page buffer pool core and its tag memory.
// ----------------------------------------------------------------------------
package lpbp_pkg;

	localparam int NUM_FRAMES = 16;
	localparam int IDX_W      = $clog2(NUM_FRAMES);
	localparam int LNK_W      = IDX_W + 1;
	localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
	localparam int OUT_MAX    = 16;
	localparam int OUT_CNT_W  = $clog2(OUT_MAX + 1);

	localparam logic [LNK_W-1:0] NIL = '1;

	localparam logic [7:0] PIN_WRITER   = 8'hFF;
	localparam logic [7:0] PIN_READ_MAX = 8'hFE;

	localparam logic [2:0] CMD_FETCH    = 3'd0;
	localparam logic [2:0] CMD_START    = 3'd1;
	localparam logic [2:0] CMD_END      = 3'd2;
	localparam logic [2:0] CMD_REL_FRM  = 3'd3;
	localparam logic [2:0] CMD_REL_FILE = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BUSY     = 2'd1;
	localparam logic [1:0] ST_NO_FRAME = 2'd2;
	localparam logic [1:0] ST_INVALID  = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] file_id;
		logic [31:0] page_num;
		logic [3:0]  frame_sel;
		logic        write_mode;
	} req_t;

	typedef struct packed {
		logic [3:0]  frame_out;
		logic        hit;
		logic [1:0]  status;
		logic        writeback_valid;
		logic [15:0] writeback_file;
		logic [31:0] writeback_page;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [15:0] file;
		logic [31:0] page;
	} tag_t;

endpackage

// File: rtl/core/lpbp_tag_mem.sv
// ----------------------------------------------------------------------------
// lpbp_tag_mem
// Single-port page tag store, one entry per frame, registered read data.
// ----------------------------------------------------------------------------
module lpbp_tag_mem (
	input  logic                      clk,
	input  logic                      en,
	input  logic                      we,
	input  logic [lpbp_pkg::IDX_W-1:0] addr,
	input  lpbp_pkg::tag_t            wdata,
	output lpbp_pkg::tag_t            rdata
);
	import lpbp_pkg::*;

	tag_t mem [NUM_FRAMES];

	// write or read one entry; read data holds while idle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/core/lru_page_buffer_pool_core.sv
// ----------------------------------------------------------------------------
// lru_page_buffer_pool_core
// Page buffer pool: tag lookup, free-frame or LRU victim choice, pin counts,
// LRU list upkeep and frame/file release, run by one sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_t (command)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_t (result)
//  cfg     | in        | cfg_we               | cfg_wdata (capacity)
//
// One command at a time. Fetch scans the tag memory with one read/compare
// pair per frame; a miss goes into a free frame or, on a full pool, into an
// unpinned victim found by an LRU walk and evicted first. Release file reads
// and compares each frame, unlinks each dropped one and hands on the results.
// Start use sets the pin; end use also moves the frame to MRU; release frame
// reads, reports and unlinks it. Reset clears all control state at once; no
// clearing pass. A stalled result holds the sequencer in place.
module lru_page_buffer_pool_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lpbp_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lpbp_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [4:0]     cfg_wdata
);
	import lpbp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_WALK, S_VIC_RD, S_VIC_WB, S_INSTALL,
		S_APPEND, S_UNLINK, S_REL_RD, S_REL_WB, S_RF_RD, S_RF_CMP, S_RF_NEXT,
		S_RF_END, S_EMIT
	} state_t;

	state_t state_q, ret_q;

	logic [4:0]       cap_q;
	logic [CNT_W-1:0] capacity;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] steps_q;
	logic [IDX_W-1:0] cnt_q, tgt_q;
	logic [LNK_W-1:0] walk_q, lru_q, mru_q;
	logic [OUT_CNT_W-1:0] k_q;
	logic             pend_q;

	logic             valid_q [NUM_FRAMES];
	logic             dirty_q [NUM_FRAMES];
	logic [7:0]       pin_q   [NUM_FRAMES];
	logic [LNK_W-1:0] older_q [NUM_FRAMES];
	logic [LNK_W-1:0] newer_q [NUM_FRAMES];

	logic [15:0] file_q;
	logic [31:0] page_q;

	rsp_t res_q, out_q;
	logic out_valid_q;
	logic out_free;
	logic out_load;

	logic             mem_en, mem_we;
	logic [IDX_W-1:0] mem_addr;
	tag_t             mem_wdata, mem_rdata;

	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic [LNK_W-1:0] tgt_older, tgt_newer;
	logic             sel_ok;
	logic [IDX_W-1:0] sel_idx;
	logic [7:0]       sel_pin;
	logic [IDX_W-1:0] walk_idx;
	logic             tag_hit, file_hit;

	lpbp_tag_mem u_tag_mem (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// clamp capacity to 1..NUM_FRAMES
	always_comb begin
		if (cap_q == 5'd0) begin
			capacity = CNT_W'(1);
		end else if (32'(cap_q) > NUM_FRAMES) begin
			capacity = CNT_W'(NUM_FRAMES);
		end else begin
			capacity = CNT_W'(cap_q);
		end
	end

	// find the lowest free frame below capacity
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (!free_found && !valid_q[i] && (i < 32'(capacity))) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign out_free  = !out_valid_q || !rsp_stall;
	assign tgt_older = older_q[tgt_q];
	assign tgt_newer = newer_q[tgt_q];
	assign sel_ok    = (32'(req.frame_sel) < NUM_FRAMES);
	assign sel_idx   = IDX_W'(req.frame_sel);
	assign sel_pin   = pin_q[sel_idx];
	assign walk_idx  = walk_q[IDX_W-1:0];
	assign file_hit  = valid_q[cnt_q] && (mem_rdata.file == file_q);
	assign tag_hit   = file_hit && (mem_rdata.page == page_q);

	// a result enters the output register this cycle
	assign out_load = out_free && ((state_q == S_EMIT) ||
		((state_q == S_RF_CMP) && file_hit && pend_q));

	// tag memory port
	always_comb begin
		mem_en    = (state_q == S_SCAN_RD) || (state_q == S_RF_RD) ||
			(state_q == S_VIC_RD) || (state_q == S_REL_RD) || (state_q == S_INSTALL);
		mem_we    = (state_q == S_INSTALL);
		mem_addr  = ((state_q == S_SCAN_RD) || (state_q == S_RF_RD)) ? cnt_q : tgt_q;
		mem_wdata = '{file: file_q, page: page_q};
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cap_q       <= 5'd16;
			used_q      <= '0;
			steps_q     <= '0;
			cnt_q       <= '0;
			tgt_q       <= '0;
			walk_q      <= NIL;
			lru_q       <= NIL;
			mru_q       <= NIL;
			k_q         <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_FRAMES; i++) begin
				valid_q[i] <= 1'b0;
				dirty_q[i] <= 1'b0;
				pin_q[i]   <= 8'd0;
				older_q[i] <= NIL;
				newer_q[i] <= NIL;
			end
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// load a new result, or drop the current one once transferred
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						file_q <= req.file_id;
						page_q <= req.page_num;
						tgt_q  <= sel_idx;
						cnt_q  <= '0;
						k_q    <= '0;
						pend_q <= 1'b0;
						res_q.hit             <= 1'b0;
						res_q.writeback_valid <= 1'b0;
						res_q.writeback_file  <= 16'd0;
						res_q.writeback_page  <= 32'd0;
						res_q.last            <= 1'b1;
						priority if (req.cmd == CMD_FETCH) begin
							res_q.frame_out <= 4'd0;
							res_q.status    <= ST_OK;
							state_q         <= S_SCAN_RD;
						end else if (req.cmd == CMD_REL_FILE) begin
							res_q.frame_out <= 4'd0;
							res_q.status    <= ST_OK;
							state_q         <= S_RF_RD;
						end else if (req.cmd == CMD_START || req.cmd == CMD_END ||
							req.cmd == CMD_REL_FRM) begin
							res_q.frame_out <= req.frame_sel;
							if (!sel_ok || !valid_q[sel_idx]) begin
								res_q.status <= ST_INVALID;
								state_q      <= S_EMIT;
							end else if (req.cmd == CMD_START) begin
								if (req.write_mode ? (sel_pin == 8'd0) :
									(sel_pin < PIN_READ_MAX)) begin
									pin_q[sel_idx] <= req.write_mode ? PIN_WRITER :
										sel_pin + 8'd1;
									res_q.status <= ST_OK;
								end else begin
									res_q.status <= ST_BUSY;
								end
								state_q <= S_EMIT;
							end else if (req.cmd == CMD_END) begin
								if (req.write_mode ? (sel_pin == PIN_WRITER) :
									(sel_pin >= 8'd1 && sel_pin <= PIN_READ_MAX)) begin
									if (req.write_mode) begin
										pin_q[sel_idx]   <= 8'd0;
										dirty_q[sel_idx] <= 1'b1;
									end else begin
										pin_q[sel_idx] <= sel_pin - 8'd1;
									end
									res_q.status <= ST_OK;
									ret_q        <= S_APPEND;
									state_q      <= S_UNLINK;
								end else begin
									res_q.status <= ST_BUSY;
									state_q      <= S_EMIT;
								end
							end else begin
								if (sel_pin != 8'd0) begin
									res_q.status <= ST_BUSY;
									state_q      <= S_EMIT;
								end else begin
									res_q.status <= ST_OK;
									state_q      <= S_REL_RD;
								end
							end
						end else begin
							res_q.frame_out <= 4'd0;
							res_q.status    <= ST_INVALID;
							state_q         <= S_EMIT;
						end
					end
				end

				// lookup: read one tag, compare it next cycle
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end

				S_SCAN_CMP: begin
					if (tag_hit) begin
						res_q.frame_out <= 4'(cnt_q);
						res_q.hit       <= 1'b1;
						state_q         <= S_EMIT;
					end else if (32'(cnt_q) != NUM_FRAMES - 1) begin
						cnt_q   <= cnt_q + IDX_W'(1);
						state_q <= S_SCAN_RD;
					end else if (used_q < capacity) begin
						if (free_found) begin
							tgt_q   <= free_idx;
							state_q <= S_INSTALL;
						end else begin
							res_q.status <= ST_NO_FRAME;
							state_q      <= S_EMIT;
						end
					end else begin
						walk_q  <= lru_q;
						steps_q <= '0;
						state_q <= S_WALK;
					end
				end

				// walk from LRU toward MRU for an unpinned frame
				S_WALK: begin
					if (walk_q == NIL || 32'(steps_q) >= NUM_FRAMES) begin
						res_q.status <= ST_NO_FRAME;
						state_q      <= S_EMIT;
					end else if (pin_q[walk_idx] != 8'd0) begin
						walk_q  <= newer_q[walk_idx];
						steps_q <= steps_q + CNT_W'(1);
					end else begin
						tgt_q   <= walk_idx;
						state_q <= S_VIC_RD;
					end
				end

				S_VIC_RD: begin
					state_q <= S_VIC_WB;
				end

				S_REL_RD: begin
					state_q <= S_REL_WB;
				end

				// evict or release the target frame, report its tag if dirty
				S_VIC_WB, S_REL_WB: begin
					res_q.writeback_valid <= dirty_q[tgt_q];
					res_q.writeback_file  <= dirty_q[tgt_q] ? mem_rdata.file : 16'd0;
					res_q.writeback_page  <= dirty_q[tgt_q] ? mem_rdata.page : 32'd0;
					res_q.frame_out       <= 4'(tgt_q);
					valid_q[tgt_q] <= 1'b0;
					dirty_q[tgt_q] <= 1'b0;
					pin_q[tgt_q]   <= 8'd0;
					if (used_q != '0) begin
						used_q <= used_q - CNT_W'(1);
					end
					ret_q   <= (state_q == S_VIC_WB) ? S_INSTALL : S_EMIT;
					state_q <= S_UNLINK;
				end

				// take the target frame out of the LRU list
				S_UNLINK: begin
					if (tgt_newer == NIL) begin
						mru_q <= tgt_older;
					end else begin
						older_q[tgt_newer[IDX_W-1:0]] <= tgt_older;
					end
					if (tgt_older == NIL) begin
						lru_q <= tgt_newer;
					end else begin
						newer_q[tgt_older[IDX_W-1:0]] <= tgt_newer;
					end
					older_q[tgt_q] <= NIL;
					newer_q[tgt_q] <= NIL;
					state_q        <= ret_q;
				end

				// load the fetched page into the target frame
				S_INSTALL: begin
					valid_q[tgt_q]  <= 1'b1;
					dirty_q[tgt_q]  <= 1'b0;
					pin_q[tgt_q]    <= 8'd0;
					used_q          <= used_q + CNT_W'(1);
					res_q.frame_out <= 4'(tgt_q);
					state_q         <= S_APPEND;
				end

				// put the target frame at MRU
				S_APPEND: begin
					older_q[tgt_q] <= mru_q;
					newer_q[tgt_q] <= NIL;
					if (mru_q != NIL) begin
						newer_q[mru_q[IDX_W-1:0]] <= LNK_W'(tgt_q);
					end
					mru_q <= LNK_W'(tgt_q);
					if (lru_q == NIL) begin
						lru_q <= LNK_W'(tgt_q);
					end
					state_q <= S_EMIT;
				end

				// release file: one frame per read/compare pair
				S_RF_RD: begin
					state_q <= S_RF_CMP;
				end

				S_RF_CMP: begin
					if (!file_hit) begin
						state_q <= S_RF_NEXT;
					end else if (!pend_q || out_free) begin
						// push the held result, hold this one until the next match or the run end
						if (pend_q) begin
							out_q <= res_q;
						end
						pend_q <= 1'b1;
						k_q    <= k_q + OUT_CNT_W'(1);
						res_q.frame_out <= 4'(cnt_q);
						res_q.hit       <= 1'b0;
						res_q.last      <= 1'b0;
						if (pin_q[cnt_q] != 8'd0) begin
							res_q.status          <= ST_BUSY;
							res_q.writeback_valid <= 1'b0;
							res_q.writeback_file  <= 16'd0;
							res_q.writeback_page  <= 32'd0;
							state_q               <= S_RF_NEXT;
						end else begin
							res_q.status          <= ST_OK;
							res_q.writeback_valid <= dirty_q[cnt_q];
							res_q.writeback_file  <= dirty_q[cnt_q] ? mem_rdata.file : 16'd0;
							res_q.writeback_page  <= dirty_q[cnt_q] ? mem_rdata.page : 32'd0;
							valid_q[cnt_q] <= 1'b0;
							dirty_q[cnt_q] <= 1'b0;
							pin_q[cnt_q]   <= 8'd0;
							if (used_q != '0) begin
								used_q <= used_q - CNT_W'(1);
							end
							tgt_q   <= cnt_q;
							ret_q   <= S_RF_NEXT;
							state_q <= S_UNLINK;
						end
					end
				end

				S_RF_NEXT: begin
					if (32'(cnt_q) == NUM_FRAMES - 1 || 32'(k_q) >= OUT_MAX) begin
						state_q <= S_RF_END;
					end else begin
						cnt_q   <= cnt_q + IDX_W'(1);
						state_q <= S_RF_RD;
					end
				end

				S_RF_END: begin
					res_q.last <= 1'b1;
					if (!pend_q) begin
						res_q.frame_out <= 4'd0;
						res_q.status    <= ST_INVALID;
					end
					state_q <= S_EMIT;
				end

				// hand the result to the output register
				S_EMIT: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page buffer pool core: drives commands through
// the request channel, predicts every result with a behavioral pool model
// (tags, pins, dirty marks, LRU order) and compares each result in order.
// ----------------------------------------------------------------------------
module tb;
	import lpbp_pkg::*;

	localparam int CYCLE_LIMIT = 900000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic cfg_we;
	logic [4:0] cfg_wdata;

	lru_page_buffer_pool_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// pool model state
	logic [4:0]  pool_cap_reg;
	logic        pool_valid [NUM_FRAMES];
	logic [15:0] pool_file [NUM_FRAMES];
	logic [31:0] pool_page [NUM_FRAMES];
	logic        pool_dirty [NUM_FRAMES];
	logic [7:0]  pool_pins [NUM_FRAMES];
	int          pool_older [NUM_FRAMES];
	int          pool_newer [NUM_FRAMES];
	int          pool_lru, pool_mru, pool_used;

	rsp_t pending_rsp [$];
	int   fail_count;
	int   cycle_count;
	int   stall_left;
	bit   rand_stall;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("** lru_page_buffer_pool_core: FAILED **");
			$finish;
		end
	end

	function automatic rsp_t make_rsp(int fr, bit h, logic [1:0] st, bit wbv,
			logic [15:0] wbf, logic [31:0] wbp, bit lst);
		rsp_t r;
		r.frame_out = fr[3:0];
		r.hit = h;
		r.status = st;
		r.writeback_valid = wbv;
		r.writeback_file = wbf;
		r.writeback_page = wbp;
		r.last = lst;
		return r;
	endfunction

	function automatic void pool_clear();
		pool_cap_reg = 5'd16;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			pool_valid[i] = 0;
			pool_file[i] = 0;
			pool_page[i] = 0;
			pool_dirty[i] = 0;
			pool_pins[i] = 0;
			pool_older[i] = -1;
			pool_newer[i] = -1;
		end
		pool_lru = -1;
		pool_mru = -1;
		pool_used = 0;
	endfunction

	function automatic void lru_unlink(int i);
		int o, n;
		o = pool_older[i];
		n = pool_newer[i];
		if (n < 0) pool_mru = o; else pool_older[n] = o;
		if (o < 0) pool_lru = n; else pool_newer[o] = n;
		pool_older[i] = -1;
		pool_newer[i] = -1;
	endfunction

	function automatic void lru_append(int i);
		pool_older[i] = pool_mru;
		pool_newer[i] = -1;
		if (pool_mru >= 0) pool_newer[pool_mru] = i;
		pool_mru = i;
		if (pool_lru < 0) pool_lru = i;
	endfunction

	// drop an unpinned frame; returns its tag when dirty
	function automatic rsp_t frame_drop(int i, bit lst);
		rsp_t r;
		r = make_rsp(i, 0, ST_OK, pool_dirty[i], pool_dirty[i] ? pool_file[i] : 16'd0,
			pool_dirty[i] ? pool_page[i] : 32'd0, lst);
		lru_unlink(i);
		pool_valid[i] = 0;
		pool_dirty[i] = 0;
		pool_pins[i] = 0;
		pool_file[i] = 0;
		pool_page[i] = 0;
		if (pool_used > 0) pool_used--;
		return r;
	endfunction

	// compute the results of one command and queue them
	function automatic void pool_predict(req_t q);
		int cap, idx, c, steps, k, sel;
		logic [7:0] p;
		bit ok;
		rsp_t r;
		cap = (pool_cap_reg < 1) ? 1 : (pool_cap_reg > NUM_FRAMES) ? NUM_FRAMES : pool_cap_reg;
		sel = q.frame_sel;
		r = make_rsp(0, 0, ST_OK, 0, 0, 0, 1);
		case (q.cmd)
			CMD_FETCH: begin
				for (int i = 0; i < NUM_FRAMES; i++)
					if (pool_valid[i] && pool_file[i] == q.file_id && pool_page[i] == q.page_num) begin
						pending_rsp.push_back(make_rsp(i, 1, ST_OK, 0, 0, 0, 1));
						return;
					end
				idx = -1;
				if (pool_used < cap) begin
					for (int i = 0; i < cap; i++)
						if (!pool_valid[i]) begin
							idx = i;
							break;
						end
				end else begin
					c = pool_lru;
					steps = 0;
					while (c >= 0 && steps < NUM_FRAMES && pool_pins[c] != 0) begin
						c = pool_newer[c];
						steps++;
					end
					if (c >= 0 && steps < NUM_FRAMES) begin
						idx = c;
						r = frame_drop(c, 1);
					end
				end
				if (idx < 0) begin
					pending_rsp.push_back(make_rsp(0, 0, ST_NO_FRAME, 0, 0, 0, 1));
					return;
				end
				pool_valid[idx] = 1;
				pool_file[idx] = q.file_id;
				pool_page[idx] = q.page_num;
				pool_dirty[idx] = 0;
				pool_pins[idx] = 0;
				pool_used++;
				lru_append(idx);
				r.frame_out = idx[3:0];
				pending_rsp.push_back(r);
			end
			CMD_START, CMD_END, CMD_REL_FRM: begin
				if (!pool_valid[sel]) begin
					pending_rsp.push_back(make_rsp(sel, 0, ST_INVALID, 0, 0, 0, 1));
					return;
				end
				p = pool_pins[sel];
				if (q.cmd == CMD_START) begin
					ok = q.write_mode ? (p == 0) : (p != PIN_WRITER && p < PIN_READ_MAX);
					if (ok) pool_pins[sel] = q.write_mode ? PIN_WRITER : p + 8'd1;
					pending_rsp.push_back(make_rsp(sel, 0, ok ? ST_OK : ST_BUSY, 0, 0, 0, 1));
				end else if (q.cmd == CMD_END) begin
					ok = q.write_mode ? (p == PIN_WRITER) : (p >= 1 && p <= PIN_READ_MAX);
					if (ok) begin
						if (q.write_mode) begin
							pool_pins[sel] = 0;
							pool_dirty[sel] = 1;
						end else pool_pins[sel] = p - 8'd1;
						lru_unlink(sel);
						lru_append(sel);
					end
					pending_rsp.push_back(make_rsp(sel, 0, ok ? ST_OK : ST_BUSY, 0, 0, 0, 1));
				end else if (p != 0) begin
					pending_rsp.push_back(make_rsp(sel, 0, ST_BUSY, 0, 0, 0, 1));
				end else begin
					pending_rsp.push_back(frame_drop(sel, 1));
				end
			end
			CMD_REL_FILE: begin
				k = 0;
				for (int i = 0; i < NUM_FRAMES && k < OUT_MAX; i++) begin
					if (!pool_valid[i] || pool_file[i] != q.file_id) continue;
					if (pool_pins[i] != 0) pending_rsp.push_back(make_rsp(i, 0, ST_BUSY, 0, 0, 0, 0));
					else pending_rsp.push_back(frame_drop(i, 0));
					k++;
				end
				if (k == 0) pending_rsp.push_back(make_rsp(0, 0, ST_INVALID, 0, 0, 0, 1));
				else pending_rsp[$].last = 1;
			end
			default: pending_rsp.push_back(make_rsp(0, 0, ST_INVALID, 0, 0, 0, 1));
		endcase
	endfunction

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result %h", $time, rsp);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.frame_out !== want.frame_out || rsp.hit !== want.hit
						|| rsp.status !== want.status
						|| rsp.writeback_valid !== want.writeback_valid
						|| rsp.writeback_file !== want.writeback_file
						|| rsp.writeback_page !== want.writeback_page
						|| rsp.last !== want.last) begin
					$display("%0t: result mismatch expected %h actual %h", $time, want, rsp);
					fail_count++;
				end
			end
		end
	end

	// result stall: mostly none, some short runs, a few long runs
	always @(posedge clk) begin
		int n;
		if (!rand_stall) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			n = $urandom_range(0, 99);
			if (n < 70) rsp_stall <= 1'b0;
			else begin
				stall_left = (n < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
				rsp_stall <= 1'b1;
			end
		end
	end

	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 99);
		if (n < 60) return;
		repeat ((n < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
	endtask

	// send one command and predict it at its transfer
	task automatic send_cmd(req_t q);
		req_valid <= 1'b1;
		req <= q;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pool_predict(q);
		req_valid <= 1'b0;
		@(posedge clk);
		idle_gap();
	endtask

	task automatic wait_drained();
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_capacity(logic [4:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pool_cap_reg = v;
	endtask

	function automatic req_t build(logic [2:0] c, logic [15:0] f, logic [31:0] pg,
			logic [3:0] s, bit w);
		req_t q;
		q.cmd = c;
		q.file_id = f;
		q.page_num = pg;
		q.frame_sel = s;
		q.write_mode = w;
		return q;
	endfunction

	// directed: extremes, every command, busy and invalid cases
	task automatic test_directed();
		send_cmd(build(CMD_START, 16'hFFFF, 32'hFFFFFFFF, 4'd15, 1));
		send_cmd(build(CMD_REL_FILE, 16'h0, 0, 0, 0));
		send_cmd(build(CMD_FETCH, 16'h0, 32'h0, 0, 0));
		send_cmd(build(CMD_FETCH, 16'hFFFF, 32'hFFFFFFFF, 0, 0));
		send_cmd(build(CMD_FETCH, 16'h0, 32'h0, 0, 0));
		send_cmd(build(CMD_START, 0, 0, 4'd0, 0));
		send_cmd(build(CMD_START, 0, 0, 4'd0, 1));
		send_cmd(build(CMD_END, 0, 0, 4'd0, 1));
		send_cmd(build(CMD_REL_FRM, 0, 0, 4'd0, 0));
		send_cmd(build(CMD_END, 0, 0, 4'd0, 0));
		send_cmd(build(CMD_END, 0, 0, 4'd0, 0));
		send_cmd(build(CMD_START, 0, 0, 4'd1, 1));
		send_cmd(build(CMD_START, 0, 0, 4'd1, 0));
		send_cmd(build(CMD_END, 0, 0, 4'd1, 1));
		send_cmd(build(CMD_REL_FILE, 16'hFFFF, 0, 0, 0));
		send_cmd(build(3'd5, 16'h1234, 32'h55AA, 4'd7, 1));
		send_cmd(build(3'd7, 0, 0, 0, 0));
		send_cmd(build(CMD_REL_FRM, 0, 0, 4'd0, 0));
	endtask

	// capacity 1: eviction, pinned victim gives no frame
	task automatic test_small_pool();
		set_capacity(5'd0);
		send_cmd(build(CMD_FETCH, 16'd3, 32'd1, 0, 0));
		send_cmd(build(CMD_START, 0, 0, 4'd0, 1));
		send_cmd(build(CMD_END, 0, 0, 4'd0, 1));
		send_cmd(build(CMD_FETCH, 16'd3, 32'd2, 0, 0));
		send_cmd(build(CMD_START, 0, 0, 4'd0, 0));
		send_cmd(build(CMD_FETCH, 16'd3, 32'd3, 0, 0));
		send_cmd(build(CMD_END, 0, 0, 4'd0, 0));
		send_cmd(build(CMD_REL_FILE, 16'd3, 0, 0, 0));
	endtask

	// random traffic on a small page space so hits, pins and evictions mix
	task automatic test_random(int count, logic [4:0] cap);
		int n;
		req_t q;
		set_capacity(cap);
		for (int j = 0; j < count; j++) begin
			n = $urandom_range(0, 99);
			q = build(3'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
				32'($urandom_range(0, 11)), 4'($urandom_range(0, 15)),
				1'($urandom_range(0, 1)));
			if (n < 3) q = req_t'(56'({$urandom, $urandom}));
			else if (n < 5) q.cmd = 3'($urandom_range(5, 7));
			else if (n < 8) begin
				q.file_id = 16'($urandom);
				q.page_num = $urandom;
			end
			if (q.cmd == CMD_REL_FILE && $urandom_range(0, 2) != 0) q.cmd = CMD_FETCH;
			send_cmd(q);
			// let every result arrive before going on
			if (j == count / 2) while (pending_rsp.size() != 0) @(posedge clk);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rand_stall = 1'b0;
		pool_clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		rand_stall = 1'b1;
		test_small_pool();
		test_random(100, 5'd16);
		test_random(100, 5'd4);
		test_random(80, 5'd31);
		rand_stall = 1'b0;
		test_random(50, 5'd8);
		rand_stall = 1'b1;
		test_random(50, 5'd2);
		wait_drained();
		if (fail_count == 0) $display("** lru_page_buffer_pool_core: PASSED **");
		else $display("** lru_page_buffer_pool_core: FAILED **");
		$finish;
	end

endmodule

// File: files.f
rtl/core/lpbp_pkg.sv
rtl/core/lpbp_tag_mem.sv
rtl/core/lru_page_buffer_pool_core.sv
test/tb.sv
